### hw/rtl/pwm_timer_register_decoder_defines.svh
// Assertion macros shared by the PWM timer register decoder RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef PWM_TIMER_REGISTER_DECODER_DEFINES_SVH
`define PWM_TIMER_REGISTER_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PTRD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define PTRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/pwm_trd_pkg.sv
// Package for the PWM timer register decoder: word types, field codes and
// prescaler tables. No dependencies.
`default_nettype none

package pwm_trd_pkg;

	// Waveform class codes.
	localparam logic [1:0] KIND_OTHER     = 2'd0;
	localparam logic [1:0] KIND_FAST      = 2'd1;
	localparam logic [1:0] KIND_PHASE     = 2'd2;
	localparam logic [1:0] KIND_PHASE_FRQ = 2'd3;

	// Output polarity codes.
	localparam logic [1:0] POL_OFF      = 2'd0;
	localparam logic [1:0] POL_NONINV   = 2'd1;
	localparam logic [1:0] POL_INV      = 2'd2;
	localparam logic [1:0] POL_RESERVED = 2'd3;

	// Timer numbers.
	localparam logic [1:0] TIMER_0 = 2'd0;
	localparam logic [1:0] TIMER_1 = 2'd1;
	localparam logic [1:0] TIMER_2 = 2'd2;

	// Compare channels.
	localparam logic CH_A = 1'b0;
	localparam logic CH_B = 1'b1;

	// Fixed counter tops of the 16-bit timer and the 8-bit timers.
	localparam logic [15:0] TOP_8BIT  = 16'h00ff;
	localparam logic [15:0] TOP_9BIT  = 16'h01ff;
	localparam logic [15:0] TOP_10BIT = 16'h03ff;

	// One snapshot word.
	typedef struct packed {
		logic [3:0]  pin;
		logic [7:0]  control_a;
		logic [7:0]  control_b;
		logic [15:0] compare_a;
		logic [15:0] compare_b;
		logic [15:0] count_now;
		logic [15:0] capture_reg;
	} snap_word_t;

	// One decoded description word.
	typedef struct packed {
		logic [1:0]  timer_number;
		logic        channel;
		logic [1:0]  waveform_kind;
		logic [10:0] prescale;
		logic [15:0] top_value;
		logic [15:0] compare_value;
		logic [15:0] counter_value;
		logic [1:0]  polarity;
		logic        snapshot_valid;
	} desc_word_t;

	// Prescaler of timers 0 and 1; the unused selects give 0.
	function automatic logic [10:0] presc_t01(input logic [2:0] cs);
		logic [10:0] p;
		case (cs)
			3'd1: p = 11'd1;
			3'd2: p = 11'd8;
			3'd3: p = 11'd64;
			3'd4: p = 11'd256;
			3'd5: p = 11'd1024;
			default: p = 11'd0;
		endcase
		return p;
	endfunction

	// Prescaler of timer 2.
	function automatic logic [10:0] presc_t2(input logic [2:0] cs);
		logic [10:0] p;
		case (cs)
			3'd1: p = 11'd1;
			3'd2: p = 11'd8;
			3'd3: p = 11'd32;
			3'd4: p = 11'd64;
			3'd5: p = 11'd128;
			3'd6: p = 11'd256;
			3'd7: p = 11'd1024;
			default: p = 11'd0;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/pwm_trd_decode.sv
// Combinational decode of one timer register snapshot into a description.
// Depends on pwm_trd_pkg.
`default_nettype none

module pwm_trd_decode import pwm_trd_pkg::*; (
	input  snap_word_t snap,
	output desc_word_t desc
);

	always_comb begin
		logic       is_t0;
		logic       is_t1;
		logic [2:0] wf8;
		logic [3:0] wf16;
		logic [1:0] code;
		logic [1:0] kind;
		logic [10:0] presc;
		logic [15:0] top;
		logic [15:0] cmp;
		logic [1:0] pol;
		logic       ch;
		logic [1:0] tnum;

		// Pin to timer and channel.
		is_t0 = (snap.pin == 4'd5) || (snap.pin == 4'd6);
		is_t1 = (snap.pin == 4'd9) || (snap.pin == 4'd10);
		if (is_t0) begin
			tnum = TIMER_0;
			ch   = (snap.pin == 4'd6) ? CH_A : CH_B;
		end else if (is_t1) begin
			tnum = TIMER_1;
			ch   = (snap.pin == 4'd9) ? CH_A : CH_B;
		end else begin
			tnum = TIMER_2;
			ch   = (snap.pin == 4'd11) ? CH_A : CH_B;
		end

		// Waveform generation bits of both timer layouts.
		wf8  = {snap.control_b[3], snap.control_a[1:0]};
		wf16 = {snap.control_b[4:3], snap.control_a[1:0]};

		// Mode, top and prescaler per timer.
		if (is_t1) begin
			presc = presc_t01(snap.control_b[2:0]);
			case (wf16) inside
				4'd5, 4'd6, 4'd7, 4'd14, 4'd15: kind = KIND_FAST;
				4'd1, 4'd2, 4'd3, 4'd10, 4'd11: kind = KIND_PHASE;
				4'd8, 4'd9:                     kind = KIND_PHASE_FRQ;
				default:                        kind = KIND_OTHER;
			endcase
			case (wf16) inside
				4'd1, 4'd5:         top = TOP_8BIT;
				4'd2, 4'd6:         top = TOP_9BIT;
				4'd3, 4'd7:         top = TOP_10BIT;
				4'd8, 4'd10, 4'd14: top = snap.capture_reg;
				4'd9, 4'd11, 4'd15: top = snap.compare_a;
				default:            top = 16'd0;
			endcase
		end else begin
			presc = is_t0 ? presc_t01(snap.control_b[2:0]) : presc_t2(snap.control_b[2:0]);
			case (wf8) inside
				3'd3, 3'd7: kind = KIND_FAST;
				3'd1, 3'd5: kind = KIND_PHASE;
				default:    kind = KIND_OTHER;
			endcase
			case (wf8) inside
				3'd5, 3'd7: top = snap.compare_a;
				default:    top = TOP_8BIT;
			endcase
		end

		// Selected compare register and its output mode.
		cmp  = (ch == CH_A) ? snap.compare_a : snap.compare_b;
		code = (ch == CH_A) ? snap.control_a[7:6] : snap.control_a[5:4];
		case (code)
			2'd0:    pol = POL_OFF;
			2'd2:    pol = POL_NONINV;
			2'd3:    pol = POL_INV;
			default: pol = POL_RESERVED;
		endcase

		desc.timer_number   = tnum;
		desc.channel        = ch;
		desc.waveform_kind  = kind;
		desc.prescale       = presc;
		desc.top_value      = top;
		desc.compare_value  = cmp;
		desc.counter_value  = snap.count_now;
		desc.polarity       = pol;
		desc.snapshot_valid = (kind != KIND_OTHER) && (pol != POL_RESERVED) &&
			(presc != 11'd0) && (top != 16'd0) && (cmp <= top) && (snap.count_now <= top);
	end

endmodule

`default_nettype wire

### hw/rtl/pwm_timer_register_decoder.sv
// Top level of the PWM timer register decoder: input register, decode, result
// register. Depends on pwm_trd_pkg, pwm_trd_decode and the assertion header.
//
//  Channel   Valid        Ready        Word
//  input     snap_valid   snap_ready   snap (snap_word_t)
//  output    desc_valid   desc_ready   desc (desc_word_t)
//
// A word is registered on acceptance and decoded from the input register; the
// result register takes the decoded word whenever it is free or being emptied,
// so one word can pass per cycle while desc_ready does not hold the result back.
// Both pipeline registers move whenever the result register is free or being
// emptied; snap_ready falls only when both stages hold a word and desc_ready is low.
// Reset empties both stages; there is no other state.
`default_nettype none

`include "pwm_timer_register_decoder_defines.svh"

module pwm_timer_register_decoder import pwm_trd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       snap_valid,
	output logic       snap_ready,
	input  snap_word_t snap,
	output logic       desc_valid,
	input  logic       desc_ready,
	output desc_word_t desc
);

	snap_word_t snap_s1;
	logic       valid_s1;
	desc_word_t desc_s2;
	logic       valid_s2;
	desc_word_t desc_comb;
	logic       load_s2;
	logic       load_s1;

	// Stage advance: the result register takes a word when free or emptied.
	assign load_s2    = !valid_s2 || desc_ready;
	assign load_s1    = !valid_s1 || load_s2;
	assign snap_ready = load_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && snap_valid) begin
			snap_s1 <= snap;
		end
	end

	// Decode of the registered snapshot.
	pwm_trd_decode u_decode (
		.snap (snap_s1),
		.desc (desc_comb)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			desc_s2 <= desc_comb;
		end
	end

	assign desc_valid = valid_s2;
	assign desc       = desc_s2;

	// An empty input stage must always take a word.
	`PTRD_ASSERT_NOW(a_empty_s1_ready, !valid_s1, snap_ready, "input stage empty but not ready")
	// A word in the input stage that cannot advance stays put.
	`PTRD_ASSERT_NEXT(a_s1_holds, valid_s1 && !load_s2, valid_s1, "input stage word lost")
	// A new result only appears after a word sat in the input stage.
	`PTRD_ASSERT_NOW(a_result_source, $rose(desc_valid), $past(valid_s1), "result without source word")
	// A valid snapshot has a real mode, polarity and clock.
	`PTRD_ASSERT_NOW(a_valid_sane, desc_valid && desc.snapshot_valid,
		desc.waveform_kind != KIND_OTHER && desc.polarity != POL_RESERVED &&
		desc.prescale != 11'd0, "snapshot flagged valid with bad fields")
	// Timer number is never the unused code.
	`PTRD_ASSERT_NOW(a_timer_range, desc_valid, desc.timer_number != 2'd3, "bad timer number")

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for the PWM timer register decoder: random and directed
// snapshots, each decoded by a local predictor and compared field by field.
// Depends on pwm_trd_pkg and the pwm_timer_register_decoder RTL.
`default_nettype none

module testbench;
	import pwm_trd_pkg::*;

	// Pins with a PWM output.
	localparam logic [3:0] PIN_T0_B = 4'd5;
	localparam logic [3:0] PIN_T0_A = 4'd6;
	localparam logic [3:0] PIN_T1_A = 4'd9;
	localparam logic [3:0] PIN_T1_B = 4'd10;
	localparam logic [3:0] PIN_T2_A = 4'd11;

	// Waveform modes of the 8-bit timers.
	localparam logic [3:0] WGM8_PC_FF    = 4'd1;
	localparam logic [3:0] WGM8_FAST_FF  = 4'd3;
	localparam logic [3:0] WGM8_PC_OCR   = 4'd5;
	localparam logic [3:0] WGM8_FAST_OCR = 4'd7;

	// Waveform modes of the 16-bit timer.
	localparam logic [3:0] WGM16_PC8      = 4'd1;
	localparam logic [3:0] WGM16_PC9      = 4'd2;
	localparam logic [3:0] WGM16_PC10     = 4'd3;
	localparam logic [3:0] WGM16_FAST8    = 4'd5;
	localparam logic [3:0] WGM16_FAST9    = 4'd6;
	localparam logic [3:0] WGM16_FAST10   = 4'd7;
	localparam logic [3:0] WGM16_PFC_ICR  = 4'd8;
	localparam logic [3:0] WGM16_PFC_OCR  = 4'd9;
	localparam logic [3:0] WGM16_PC_ICR   = 4'd10;
	localparam logic [3:0] WGM16_PC_OCR   = 4'd11;
	localparam logic [3:0] WGM16_FAST_ICR = 4'd14;
	localparam logic [3:0] WGM16_FAST_OCR = 4'd15;

	// Raw compare-output mode codes.
	localparam logic [1:0] COM_OFF   = 2'd0;
	localparam logic [1:0] COM_CLEAR = 2'd2;
	localparam logic [1:0] COM_SET   = 2'd3;

	// Clock dividers indexed by clock select.
	localparam logic [10:0] DIV_T01 [0:7] = '{11'd0, 11'd1, 11'd8, 11'd64, 11'd256,
		11'd1024, 11'd0, 11'd0};
	localparam logic [10:0] DIV_T2 [0:7] = '{11'd0, 11'd1, 11'd8, 11'd32, 11'd64,
		11'd128, 11'd256, 11'd1024};

	localparam int IDLE_PERCENT = 27;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;

	logic       clk;
	logic       arst_n;
	logic       snap_valid;
	logic       snap_ready;
	snap_word_t snap;
	logic       desc_valid;
	logic       desc_ready;
	desc_word_t desc;

	snap_word_t pending_snaps [$];
	desc_word_t awaited_descs [$];
	int         snaps_issued = 0;
	int         snaps_accepted = 0;
	int         total_snaps = 0;
	int         mismatches = 0;
	int         quiet_cycles = 0;
	int         hold_left = 0;
	bit         held_once = 0;

	pwm_timer_register_decoder uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap),
		.desc_valid (desc_valid),
		.desc_ready (desc_ready),
		.desc       (desc)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Decode one register snapshot into the description the block should give.
	function automatic desc_word_t decode_snapshot(input snap_word_t s);
		desc_word_t d;
		logic [3:0] wgm;
		logic [1:0] com;
		d = '0;
		d.counter_value = s.count_now;
		if (s.pin == PIN_T1_A || s.pin == PIN_T1_B) begin
			d.timer_number = TIMER_1;
			d.channel = (s.pin == PIN_T1_A) ? CH_A : CH_B;
			d.prescale = DIV_T01[s.control_b[2:0]];
			wgm = {s.control_b[4:3], s.control_a[1:0]};
			case (wgm)
				WGM16_FAST8, WGM16_FAST9, WGM16_FAST10, WGM16_FAST_ICR, WGM16_FAST_OCR:
					d.waveform_kind = KIND_FAST;
				WGM16_PC8, WGM16_PC9, WGM16_PC10, WGM16_PC_ICR, WGM16_PC_OCR:
					d.waveform_kind = KIND_PHASE;
				WGM16_PFC_ICR, WGM16_PFC_OCR:
					d.waveform_kind = KIND_PHASE_FRQ;
				default:
					d.waveform_kind = KIND_OTHER;
			endcase
			case (wgm)
				WGM16_PC8, WGM16_FAST8:                        d.top_value = TOP_8BIT;
				WGM16_PC9, WGM16_FAST9:                        d.top_value = TOP_9BIT;
				WGM16_PC10, WGM16_FAST10:                      d.top_value = TOP_10BIT;
				WGM16_PFC_ICR, WGM16_PC_ICR, WGM16_FAST_ICR: d.top_value = s.capture_reg;
				WGM16_PFC_OCR, WGM16_PC_OCR, WGM16_FAST_OCR: d.top_value = s.compare_a;
				default:                                       d.top_value = '0;
			endcase
		end else begin
			// Timer 0 on its two pins; every other pin falls to timer 2.
			if (s.pin == PIN_T0_A || s.pin == PIN_T0_B) begin
				d.timer_number = TIMER_0;
				d.channel = (s.pin == PIN_T0_A) ? CH_A : CH_B;
				d.prescale = DIV_T01[s.control_b[2:0]];
			end else begin
				d.timer_number = TIMER_2;
				d.channel = (s.pin == PIN_T2_A) ? CH_A : CH_B;
				d.prescale = DIV_T2[s.control_b[2:0]];
			end
			wgm = {1'b0, s.control_b[3], s.control_a[1:0]};
			case (wgm)
				WGM8_FAST_FF, WGM8_FAST_OCR: d.waveform_kind = KIND_FAST;
				WGM8_PC_FF, WGM8_PC_OCR:     d.waveform_kind = KIND_PHASE;
				default:                     d.waveform_kind = KIND_OTHER;
			endcase
			d.top_value = (wgm == WGM8_PC_OCR || wgm == WGM8_FAST_OCR) ? s.compare_a : TOP_8BIT;
		end
		// Channel selection drives both the compare value and the output mode.
		d.compare_value = (d.channel == CH_A) ? s.compare_a : s.compare_b;
		com = (d.channel == CH_A) ? s.control_a[7:6] : s.control_a[5:4];
		case (com)
			COM_OFF:   d.polarity = POL_OFF;
			COM_CLEAR: d.polarity = POL_NONINV;
			COM_SET:   d.polarity = POL_INV;
			default:   d.polarity = POL_RESERVED;
		endcase
		d.snapshot_valid = d.waveform_kind != KIND_OTHER && d.polarity != POL_RESERVED &&
			d.prescale != '0 && d.top_value != '0 &&
			d.compare_value <= d.top_value && d.counter_value <= d.top_value;
		return d;
	endfunction

	// Draw a snapshot with a defined mode, a running clock and values that sit
	// within the top, with the odd counter value pushed just past it.
	function automatic snap_word_t sane_snapshot();
		snap_word_t s;
		desc_word_t d;
		logic [15:0] top;
		s = '0;
		do begin
			case ($urandom_range(0, 5))
				0:       s.pin = PIN_T0_B;
				1:       s.pin = PIN_T0_A;
				2:       s.pin = PIN_T1_A;
				3:       s.pin = PIN_T1_B;
				4:       s.pin = PIN_T2_A;
				default: s.pin = 4'($urandom_range(0, 15));
			endcase
			s.control_a = 8'($urandom_range(0, 255));
			s.control_b = 8'($urandom_range(0, 255));
			s.capture_reg = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
				: 16'($urandom_range(1, 1023));
			s.compare_a = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
				: 16'($urandom_range(1, 1023));
			d = decode_snapshot(s);
		end while (d.waveform_kind == KIND_OTHER || d.polarity == POL_RESERVED ||
			d.prescale == '0 || d.top_value == '0);
		top = d.top_value;
		if (top != s.compare_a)
			s.compare_a = 16'($urandom_range(0, top));
		s.compare_b = 16'($urandom_range(0, top));
		s.count_now = 16'($urandom_range(0, top));
		if ($urandom_range(0, 7) == 0 && top != 16'hffff)
			s.count_now = top + 16'd1;
		return s;
	endfunction

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Sender: offers the next pending word, holding it until it is taken.
	always @(negedge clk) begin
		if (arst_n && (!snap_valid || snaps_accepted == snaps_issued)) begin
			if (pending_snaps.size() != 0 &&
					((snaps_issued >= 150 && snaps_issued < 250) ||
					$urandom_range(0, 99) >= IDLE_PERCENT)) begin
				snap <= pending_snaps.pop_front();
				snap_valid <= 1'b1;
				snaps_issued++;
			end else begin
				snap_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, one long hold-off, and a stretch with no stalls.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				desc_ready <= 1'b0;
			end else if (!held_once && snaps_accepted >= 300) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES;
				desc_ready <= 1'b0;
			end else if (snaps_accepted >= 150 && snaps_accepted < 250) begin
				desc_ready <= 1'b1;
			end else begin
				desc_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	// Monitor: checks each result word against the oldest awaited one, then
	// records the description that an accepted snapshot should produce.
	always @(posedge clk) begin : monitor
		desc_word_t want;
		if (arst_n) begin
			if (desc_valid && desc_ready) begin
				if (awaited_descs.size() == 0) begin
					report_mismatch("word with nothing awaited, counter_value",
						longint'(desc.counter_value), longint'(0));
				end else begin
					want = awaited_descs.pop_front();
					if (desc.timer_number !== want.timer_number)
						report_mismatch("timer_number", longint'(desc.timer_number),
							longint'(want.timer_number));
					if (desc.channel !== want.channel)
						report_mismatch("channel", longint'(desc.channel),
							longint'(want.channel));
					if (desc.waveform_kind !== want.waveform_kind)
						report_mismatch("waveform_kind", longint'(desc.waveform_kind),
							longint'(want.waveform_kind));
					if (desc.prescale !== want.prescale)
						report_mismatch("prescale", longint'(desc.prescale),
							longint'(want.prescale));
					if (desc.top_value !== want.top_value)
						report_mismatch("top_value", longint'(desc.top_value),
							longint'(want.top_value));
					if (desc.compare_value !== want.compare_value)
						report_mismatch("compare_value", longint'(desc.compare_value),
							longint'(want.compare_value));
					if (desc.counter_value !== want.counter_value)
						report_mismatch("counter_value", longint'(desc.counter_value),
							longint'(want.counter_value));
					if (desc.polarity !== want.polarity)
						report_mismatch("polarity", longint'(desc.polarity),
							longint'(want.polarity));
					if (desc.snapshot_valid !== want.snapshot_valid)
						report_mismatch("snapshot_valid", longint'(desc.snapshot_valid),
							longint'(want.snapshot_valid));
				end
			end
			if (snap_valid && snap_ready) begin
				awaited_descs.push_back(decode_snapshot(snap));
				snaps_accepted++;
			end
		end
	end

	// Watchdog: ends the run when neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (snap_valid && snap_ready) || (desc_valid && desc_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("pwm_timer_register_decoder: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		snap_word_t s;
		logic [3:0] pins8 [0:7];
		pins8 = '{PIN_T0_B, PIN_T0_A, PIN_T2_A, 4'd0, 4'd3, 4'd15, 4'd13, 4'd2};
		clk = 1'b0;
		arst_n = 1'b0;
		snap_valid = 1'b0;
		snap = '0;
		desc_ready = 1'b0;

		// Every mode of the 16-bit timer, both channels, every clock select.
		for (int m = 0; m < 16; m++) begin
			s.pin = m[0] ? PIN_T1_B : PIN_T1_A;
			s.control_a = {m[1:0], m[3:2], 2'b00, m[1:0]};
			s.control_b = {3'b000, m[3:2], m[2:0]};
			s.compare_a = 16'h00f0;
			s.compare_b = 16'h0080;
			s.count_now = 16'h0010;
			s.capture_reg = 16'h0100;
			pending_snaps.push_back(s);
		end
		// Every mode of the 8-bit timers on PWM and non-PWM pins, one counter past
		// the fixed top.
		for (int m = 0; m < 8; m++) begin
			s.pin = pins8[m];
			s.control_a = {COM_CLEAR, COM_SET, 2'b00, m[1:0]};
			s.control_b = {4'b0000, m[2], 3'd7 - m[2:0]};
			s.compare_a = 16'h00c0;
			s.compare_b = 16'h0040;
			s.count_now = (m == 6) ? 16'h0100 : 16'h0020;
			s.capture_reg = 16'hffff;
			pending_snaps.push_back(s);
		end
		// Field extremes.
		pending_snaps.push_back('0);
		pending_snaps.push_back('1);

		// Random part: mostly well-formed snapshots, the rest raw noise.
		repeat (400) begin
			if ($urandom_range(0, 99) < 75) begin
				s = sane_snapshot();
			end else begin
				s.pin = 4'($urandom_range(0, 15));
				s.control_a = 8'($urandom_range(0, 255));
				s.control_b = 8'($urandom_range(0, 255));
				s.compare_a = 16'($urandom_range(0, 65535));
				s.compare_b = 16'($urandom_range(0, 65535));
				s.count_now = 16'($urandom_range(0, 65535));
				s.capture_reg = 16'($urandom_range(0, 65535));
			end
			pending_snaps.push_back(s);
		end
		total_snaps = pending_snaps.size();

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		while (snaps_accepted != total_snaps || awaited_descs.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0) begin
			$display("pwm_timer_register_decoder: match");
		end else begin
			$display("pwm_timer_register_decoder: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
+incdir+hw/rtl
hw/rtl/pwm_trd_pkg.sv
hw/rtl/pwm_trd_decode.sv
hw/rtl/pwm_timer_register_decoder.sv
dv/testbench.sv
